@@ hdl/plfe_pkg.sv @@
package plfe_pkg;

    localparam int SIDE   = 5;
    localparam int CODE_W = 5;
    localparam int ROW_W  = SIDE * CODE_W;
    localparam int CELLS  = SIDE * SIDE;
    localparam int POS_W  = 3;
    localparam int IDX_W  = 3;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CELLS-1:0]  t_match;
    typedef t_row [SIDE-1:0]   t_square;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_SQUARE_ROW_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_SQUARE_ROW_4 = 3'd4;

    // Key square P E S U N / I V R T Y / A B C D F / G H K L M / O Q W X Z.
    localparam t_square SQUARE_RESET = '{
        25'd26991118, 25'd12953830, 25'd5343264, 25'd25806504, 25'd14305423
    };

    typedef struct packed {
        t_code plain_first;
        t_code plain_second;
    } t_plain;

    typedef struct packed {
        t_code cipher_first;
        t_code cipher_second;
        logic  not_found;
    } t_cipher;

endpackage

@@ hdl/plfe_match.sv @@
module plfe_match (
    input  plfe_pkg::t_square i_square,
    input  plfe_pkg::t_code   i_code,
    output plfe_pkg::t_match  o_match
);
    import plfe_pkg::*;

    // One equality compare per square entry; bit r*SIDE+c marks row r, column c.
    always_comb begin
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                o_match[r*SIDE + c] = (i_square[r][c*CODE_W +: CODE_W] == i_code);
            end
        end
    end

endmodule

@@ hdl/playfair_digraph_encrypt_unit.sv @@
// Playfair digraph encryption over a programmable 5x5 key square.
// Input channel: i_in_valid / o_in_ready carry one letter pair per beat.
// Output channel: o_out_valid / i_out_ready carry the cipher pair and a
// not_found flag per beat, in the order the pairs were accepted.
// Configuration: i_cfg_we writes i_cfg_data into square row i_cfg_index;
// indexes above four are ignored. Write only while the pipeline is empty.
// Throughput: one pair per cycle while the receiver does not stall, set by
// the five-stage pipeline (compare, row select, column select, rule, cell
// read), each stage one register deep.
// When the receiver stalls, the stalled output and every stage behind it
// holds; earlier empty stages keep filling, so o_in_ready drops only once
// all five stages hold a beat.
// Reset clears all stage valid bits and loads the default key square.
module playfair_digraph_encrypt_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  plfe_pkg::t_plain              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output plfe_pkg::t_cipher             o_out_data,
    input  logic                          i_cfg_we,
    input  logic [plfe_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [plfe_pkg::ROW_W-1:0]    i_cfg_data
);
    import plfe_pkg::*;

    typedef struct packed {
        t_match match_a;
        t_match match_b;
    } t_s1;

    typedef struct packed {
        logic  found_a;
        logic  found_b;
        t_pos  row_a;
        t_pos  row_b;
        logic [SIDE-1:0] seg_a;
        logic [SIDE-1:0] seg_b;
    } t_s2;

    typedef struct packed {
        logic found_a;
        logic found_b;
        t_pos row_a;
        t_pos col_a;
        t_pos row_b;
        t_pos col_b;
    } t_s3;

    typedef struct packed {
        logic not_found;
        t_pos row_x;
        t_pos col_x;
        t_pos row_y;
        t_pos col_y;
    } t_s4;

    function automatic t_pos wrap_inc(input t_pos p);
        return (p == t_pos'(SIDE - 1)) ? '0 : t_pos'(p + 1'b1);
    endfunction

    t_square r_square;
    logic    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic    en1, en2, en3, en4, en5;
    t_s1     r_s1, n_s1;
    t_s2     r_s2, n_s2;
    t_s3     r_s3, n_s3;
    t_s4     r_s4, n_s4;
    t_cipher r_out, n_out;
    t_match  match_a, match_b;

    // A stage may load when it is empty or when its beat moves on this cycle.
    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v5;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= SQUARE_RESET;
        end else if (i_cfg_we && i_cfg_index <= REG_SQUARE_ROW_4) begin
            r_square[i_cfg_index] <= i_cfg_data;
        end
    end

    plfe_match u_match_a (
        .i_square (r_square),
        .i_code   (i_in_data.plain_first),
        .o_match  (match_a)
    );

    plfe_match u_match_b (
        .i_square (r_square),
        .i_code   (i_in_data.plain_second),
        .o_match  (match_b)
    );

    assign n_s1.match_a = match_a;
    assign n_s1.match_b = match_b;

    // The last matching row wins, then the last matching column within it.
    always_comb begin
        n_s2         = '0;
        n_s2.found_a = |r_s1.match_a;
        n_s2.found_b = |r_s1.match_b;
        for (int r = 0; r < SIDE; r++) begin
            if (|r_s1.match_a[r*SIDE +: SIDE]) begin
                n_s2.row_a = t_pos'(r);
                n_s2.seg_a = r_s1.match_a[r*SIDE +: SIDE];
            end
            if (|r_s1.match_b[r*SIDE +: SIDE]) begin
                n_s2.row_b = t_pos'(r);
                n_s2.seg_b = r_s1.match_b[r*SIDE +: SIDE];
            end
        end
    end

    always_comb begin
        n_s3         = '0;
        n_s3.found_a = r_s2.found_a;
        n_s3.found_b = r_s2.found_b;
        n_s3.row_a   = r_s2.row_a;
        n_s3.row_b   = r_s2.row_b;
        for (int c = 0; c < SIDE; c++) begin
            if (r_s2.seg_a[c]) begin
                n_s3.col_a = t_pos'(c);
            end
            if (r_s2.seg_b[c]) begin
                n_s3.col_b = t_pos'(c);
            end
        end
    end

    always_comb begin
        n_s4           = '0;
        n_s4.not_found = !(r_s3.found_a && r_s3.found_b);
        if (r_s3.row_a == r_s3.row_b) begin
            n_s4.row_x = r_s3.row_a;
            n_s4.col_x = wrap_inc(r_s3.col_a);
            n_s4.row_y = r_s3.row_b;
            n_s4.col_y = wrap_inc(r_s3.col_b);
        end else if (r_s3.col_a == r_s3.col_b) begin
            n_s4.row_x = wrap_inc(r_s3.row_a);
            n_s4.col_x = r_s3.col_a;
            n_s4.row_y = wrap_inc(r_s3.row_b);
            n_s4.col_y = r_s3.col_b;
        end else begin
            n_s4.row_x = r_s3.row_a;
            n_s4.col_x = r_s3.col_b;
            n_s4.row_y = r_s3.row_b;
            n_s4.col_y = r_s3.col_a;
        end
    end

    always_comb begin
        n_out = '0;
        n_out.not_found = r_s4.not_found;
        if (!r_s4.not_found) begin
            n_out.cipher_first  = r_square[r_s4.row_x][r_s4.col_x*CODE_W +: CODE_W];
            n_out.cipher_second = r_square[r_s4.row_y][r_s4.col_y*CODE_W +: CODE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1  <= n_s1;
        if (en2) r_s2  <= n_s2;
        if (en3) r_s3  <= n_s3;
        if (en4) r_s4  <= n_s4;
        if (en5) r_out <= n_out;
    end

    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.not_found |->
            o_out_data.cipher_first == '0 && o_out_data.cipher_second == '0)
        else $error("not_found beat carries nonzero cipher letters");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_in_ready)
        else $error("input refused while first stage is empty");

    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !en4 |=> r_v4 && $stable(r_s4))
        else $error("rule stage lost or changed a stalled beat");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_s3.found_a && r_s3.found_b |->
            r_s3.row_a < t_pos'(SIDE) && r_s3.col_a < t_pos'(SIDE) &&
            r_s3.row_b < t_pos'(SIDE) && r_s3.col_b < t_pos'(SIDE))
        else $error("located position outside the square");

    a_out_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && o_out_valid && i_out_ready |=> o_out_valid)
        else $error("beat dropped between rule stage and output");

endmodule
